>>> hw/rtl/psgwsf_pkg.sv
// ----------------------------------------------------------------------------
// psgwsf_pkg
// Shared widths, register map, constant bytes and the silencing table for the
// sound chip write stream fixer.
// ----------------------------------------------------------------------------
`default_nettype none

package psgwsf_pkg;

   localparam int BYTE_W     = 8;
   localparam int PERIOD_W   = 10;
   localparam int CHAN_W     = 2;
   localparam int NUM_TONES  = 3;
   localparam int LEN_W      = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic REG_FIX_ENABLE      = 1'b0;
   localparam logic REG_PERIODIC_ENABLE = 1'b1;

   localparam logic [LEN_W-1:0] RESET_LEN = 4'd10;

   localparam logic [BYTE_W-1:0] ATT2_MUTED  = 8'hDF;
   localparam logic [3:0]        TONE3_LATCH = 4'hC;
   localparam logic [3:0]        NOISE_CTRL  = 4'hE;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [PERIOD_W-1:0] period_type;

   // silencing sequence: per tone attenuation off, then period zero; noise attenuation off last
   function automatic byte_type reset_byte(input logic [LEN_W-1:0] idx);
      byte_type b;
      case (idx)
         4'd0:    b = 8'h9F;
         4'd1:    b = 8'h80;
         4'd2:    b = 8'h00;
         4'd3:    b = 8'hBF;
         4'd4:    b = 8'hA0;
         4'd5:    b = 8'h00;
         4'd6:    b = 8'hDF;
         4'd7:    b = 8'hC0;
         4'd8:    b = 8'h00;
         4'd9:    b = 8'hFF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/psgwsf_req_if.sv
// ----------------------------------------------------------------------------
// psgwsf_req_if
// Command channel: one operation code and one chip command byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface psgwsf_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [psgwsf_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/psgwsf_rsp_if.sv
// ----------------------------------------------------------------------------
// psgwsf_rsp_if
// Bus byte channel: one chip byte per transfer, last marks the end of a group.
// ----------------------------------------------------------------------------
`default_nettype none

interface psgwsf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psgwsf_pkg::BYTE_W-1:0] out_byte;
   logic                          last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/psg_write_stream_fixer.sv
// ----------------------------------------------------------------------------
// psg_write_stream_fixer
// Rewrites the command byte stream of a four-channel sound generator: keeps
// shadow tone periods, forces zero periods to one, sends low and high bytes
// together, stretches tone 3 by 17/16 if muted and driving periodic noise.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | op, data_byte
//   rsp     | out | valid/ready   | out_byte, last
//   csr     | in  | APB-style     | fix_enable, periodic_fix_enable
//
// A command is decoded in the cycle it is taken; its bytes leave one a cycle
// from a group register through the output register while rsp.ready holds.
// A command yields 1 to 3 bytes, a reset op 10, so the rate is one output
// byte per cycle when rsp is ready, set by the single output register.
// req.ready is high when the group register is empty or sends its last byte.
// Synchronous reset clears configuration, shadow state and handshake control; no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_write_stream_fixer (
   input  wire                                   clock,
   input  wire                                   reset,
   psgwsf_req_if.sink                            req,
   psgwsf_rsp_if.source                          rsp,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [psgwsf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [psgwsf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [psgwsf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   localparam int NT = psgwsf_pkg::NUM_TONES;
   localparam int LW = psgwsf_pkg::LEN_W;

   // configuration
   logic fix_ff, fix_in;
   logic pfe_ff, pfe_in;

   // shadow state
   logic [psgwsf_pkg::CHAN_W-1:0] lc_ff, lc_in;
   psgwsf_pkg::period_type        tp_ff [NT];
   psgwsf_pkg::period_type        tp_in [NT];
   logic                          mute2_ff, mute2_in;
   logic                          np_ff, np_in;
   logic                          nt3_ff, nt3_in;

   // byte group
   logic                          job_valid_ff, job_valid_in;
   logic                          job_reset_ff, job_reset_in;
   logic [LW-1:0]                 job_len_ff, job_len_in;
   logic [LW-1:0]                 job_idx_ff, job_idx_in;
   psgwsf_pkg::byte_type          job_byte_ff [NT];
   psgwsf_pkg::byte_type          job_byte_in [NT];

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   psgwsf_pkg::byte_type          rsp_byte_ff, rsp_byte_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          csr_wr;
   logic                          req_xfer;
   logic                          out_free;
   logic                          job_step;
   logic                          job_is_last;
   logic                          job_done;
   psgwsf_pkg::byte_type          d;
   logic [psgwsf_pkg::CHAN_W-1:0] ch_hi;
   psgwsf_pkg::period_type        tp_sel_hi;
   psgwsf_pkg::period_type        tp_sel_lo;
   psgwsf_pkg::period_type        p_hi;
   psgwsf_pkg::period_type        p_lo;
   psgwsf_pkg::period_type        tp_new [NT];
   logic [psgwsf_pkg::CHAN_W-1:0] lc_new;
   logic                          mute2_new, np_new, nt3_new;
   logic [14:0]                   prod;
   logic [10:0]                   pr;
   psgwsf_pkg::byte_type          r0, r1;
   psgwsf_pkg::byte_type          nb [NT];
   logic [LW-1:0]                 nlen;
   logic                          nreset;
   psgwsf_pkg::byte_type          cur_byte;

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      fix_in = fix_ff;
      pfe_in = pfe_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            psgwsf_pkg::REG_FIX_ENABLE:      fix_in = csr_pwdata[0];
            psgwsf_pkg::REG_PERIODIC_ENABLE: pfe_in = csr_pwdata[0];
            default:                         fix_in = fix_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         psgwsf_pkg::REG_FIX_ENABLE:      csr_prdata = {31'd0, fix_ff};
         psgwsf_pkg::REG_PERIODIC_ENABLE: csr_prdata = {31'd0, pfe_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   // ---- handshake ----
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign job_step    = job_valid_ff && out_free;
   assign job_is_last = (job_idx_ff == job_len_ff - 4'd1);
   assign job_done    = job_step && job_is_last;
   assign req.ready   = !job_valid_ff || job_done;
   assign req_xfer    = req.valid && req.ready;
   assign d           = req.data_byte;

   // ---- decode: next shadow state ----
   always_comb begin
      case (lc_ff)
         2'd0:    ch_hi = 2'd0;
         2'd1:    ch_hi = 2'd1;
         default: ch_hi = 2'd2;
      endcase
      case (ch_hi)
         2'd0:    tp_sel_hi = tp_ff[0];
         2'd1:    tp_sel_hi = tp_ff[1];
         default: tp_sel_hi = tp_ff[2];
      endcase
      case (d[6:5])
         2'd0:    tp_sel_lo = tp_ff[0];
         2'd1:    tp_sel_lo = tp_ff[1];
         default: tp_sel_lo = tp_ff[2];
      endcase
      p_hi = {d[5:0], tp_sel_hi[3:0]};
      p_lo = {tp_sel_lo[9:4], d[3:0]};
   end

   always_comb begin
      lc_new    = lc_ff;
      mute2_new = mute2_ff;
      np_new    = np_ff;
      nt3_new   = nt3_ff;
      for (int i = 0; i < NT; i++) begin
         tp_new[i] = tp_ff[i];
      end
      if (req.op) begin
         lc_new = '0;
         for (int i = 0; i < NT; i++) begin
            tp_new[i] = '0;
         end
      end else if (fix_ff) begin
         if (!d[7]) begin
            for (int i = 0; i < NT; i++) begin
               if (ch_hi == i[1:0]) tp_new[i] = p_hi;
            end
         end else if (!d[4] && d[6:5] != 2'd3) begin
            lc_new = d[6:5];
            for (int i = 0; i < NT; i++) begin
               if (d[6:5] == i[1:0]) tp_new[i] = p_lo;
            end
         end else if (d[4]) begin
            if (d[6:5] == 2'd2) mute2_new = (d == psgwsf_pkg::ATT2_MUTED);
         end else if (d[7:4] == psgwsf_pkg::NOISE_CTRL) begin
            np_new  = !d[2];
            nt3_new = (d[1:0] == 2'b11);
         end
      end
   end

   // ---- tone 3 refresh from the updated state ----
   always_comb begin
      prod = {5'd0, tp_new[2]} * 15'd17;
      if (pfe_ff && np_new && nt3_new && mute2_new) begin
         pr = prod[14:4];
      end else begin
         pr = {1'b0, tp_new[2]};
      end
      if (pr == 11'd0) pr = 11'd1;
      r0 = {psgwsf_pkg::TONE3_LATCH, pr[3:0]};
      r1 = {2'b00, pr[9:4]};
   end

   // ---- decode: byte group ----
   always_comb begin
      nreset = 1'b0;
      nlen   = 4'd1;
      nb[0]  = d;
      nb[1]  = '0;
      nb[2]  = '0;
      if (req.op) begin
         nreset = 1'b1;
         nlen   = psgwsf_pkg::RESET_LEN;
      end else if (!fix_ff) begin
         nb[0] = d;
      end else if (!d[7]) begin
         nlen = 4'd2;
         if (ch_hi == 2'd2) begin
            nb[0] = r0;
            nb[1] = r1;
         end else begin
            nb[0] = {1'b1, ch_hi, 1'b0, p_hi[3:1], p_hi[0] | (p_hi == '0)};
            nb[1] = {2'b00, d[5:0]};
         end
      end else if (!d[4] && d[6:5] != 2'd3) begin
         nb[0] = {d[7:1], d[0] | (p_lo == '0)};
      end else if ((d[4] && d[6:5] == 2'd2) || (!d[4] && d[7:4] == psgwsf_pkg::NOISE_CTRL))
      begin
         nlen  = 4'd3;
         nb[0] = r0;
         nb[1] = r1;
         nb[2] = d;
      end
   end

   // ---- group register and output register ----
   always_comb begin
      case (job_idx_ff[1:0])
         2'd0:    cur_byte = job_byte_ff[0];
         2'd1:    cur_byte = job_byte_ff[1];
         default: cur_byte = job_byte_ff[2];
      endcase
      if (job_reset_ff) cur_byte = psgwsf_pkg::reset_byte(job_idx_ff);
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_reset_in = job_reset_ff;
      job_len_in   = job_len_ff;
      job_idx_in   = job_idx_ff;
      for (int i = 0; i < NT; i++) begin
         job_byte_in[i] = job_byte_ff[i];
      end
      if (req_xfer) begin
         job_valid_in = 1'b1;
         job_reset_in = nreset;
         job_len_in   = nlen;
         job_idx_in   = '0;
         for (int i = 0; i < NT; i++) begin
            job_byte_in[i] = nb[i];
         end
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (job_step) begin
         job_idx_in = job_idx_ff + 4'd1;
      end

      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      if (job_step) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = job_is_last;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp.ready;
      end

      lc_in    = req_xfer ? lc_new    : lc_ff;
      mute2_in = req_xfer ? mute2_new : mute2_ff;
      np_in    = req_xfer ? np_new    : np_ff;
      nt3_in   = req_xfer ? nt3_new   : nt3_ff;
      for (int i = 0; i < NT; i++) begin
         tp_in[i] = req_xfer ? tp_new[i] : tp_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ff       <= 1'b0;
         pfe_ff       <= 1'b0;
         lc_ff        <= '0;
         mute2_ff     <= 1'b0;
         np_ff        <= 1'b0;
         nt3_ff       <= 1'b0;
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NT; i++) begin
            tp_ff[i] <= '0;
         end
      end else begin
         fix_ff       <= fix_in;
         pfe_ff       <= pfe_in;
         lc_ff        <= lc_in;
         mute2_ff     <= mute2_in;
         np_ff        <= np_in;
         nt3_ff       <= nt3_in;
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NT; i++) begin
            tp_ff[i] <= tp_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      job_reset_ff <= job_reset_in;
      job_len_ff   <= job_len_in;
      job_idx_ff   <= job_idx_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      for (int i = 0; i < NT; i++) begin
         job_byte_ff[i] <= job_byte_in[i];
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.last     = rsp_last_ff;

   // ---- assertions ----
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("command taken while output stalled");

   a_reset_group: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.op) |=>
      (job_valid_ff && job_reset_ff && job_len_ff == psgwsf_pkg::RESET_LEN))
      else $error("reset op did not load silencing group");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_idx_ff < job_len_ff))
      else $error("group index beyond length");

   a_latch_range: assert property (@(posedge clock) disable iff (reset)
      lc_ff != 2'd3)
      else $error("latched channel out of range");

endmodule

`default_nettype wire

>>> bench/psg_write_stream_fixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_write_stream_fixer_tb
// Self-checking bench for the sound chip write stream fixer. A directed table
// covers pass-through, silencing, forced zero periods, paired tone writes and
// the tone 3 stretch with overflow; random command streams follow under
// several register settings, with random gaps on both channels. Every bus
// byte is compared with a shadow copy of the rewriting rules.
// ----------------------------------------------------------------------------

module psg_write_stream_fixer_tb;

   localparam logic OP_WRITE      = 1'b0;
   localparam logic OP_SILENCE    = 1'b1;
   localparam int   N_DIRECTED    = 25;
   localparam int   N_PHASES      = 5;
   localparam int   PHASE_ITEMS   = 61;
   localparam int   SETTLE_CYCLES = 4;
   // per random phase, bit n: register settings
   localparam logic [N_PHASES-1:0] PHASE_FIX     = 5'b01011;
   localparam logic [N_PHASES-1:0] PHASE_STRETCH = 5'b01101;

   typedef struct packed {
      psgwsf_pkg::byte_type out_byte;
      logic                 last;
   } bus_byte_type;

   // typed bytes are right aligned, first byte leftmost
   typedef struct packed {
      logic                 fix;
      logic                 stretch;
      logic                 op;
      psgwsf_pkg::byte_type data;
      logic [3:0]           n_typed;
      logic [79:0]          typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [psgwsf_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [psgwsf_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [psgwsf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   psgwsf_req_if req_bus ();
   psgwsf_rsp_if rsp_bus ();

   psg_write_stream_fixer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and tone state
   logic                   fix_en           = 1'b0;
   logic                   stretch_en       = 1'b0;
   logic [1:0]             shadow_latch     = 2'd0;
   psgwsf_pkg::period_type shadow_period [psgwsf_pkg::NUM_TONES] = '{default: '0};
   psgwsf_pkg::byte_type   shadow_atten [4] = '{default: '0};
   logic                   noise_periodic_q = 1'b0;
   logic                   noise_tone3_q    = 1'b0;

   psgwsf_pkg::byte_type group_bytes [$];
   bus_byte_type         bus_bytes_due [$];
   int                   errors      = 0;
   logic                 steady_send = 1'b0;
   int                   ready_hold  = 0;
   logic                 ready_mode  = 1'b0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      {1'b0, 1'b0, OP_WRITE,   8'h00, 4'd1,  80'h00},
      {1'b0, 1'b0, OP_WRITE,   8'hFF, 4'd1,  80'hFF},
      {1'b0, 1'b0, OP_WRITE,   8'h8A, 4'd1,  80'h8A},
      {1'b0, 1'b0, OP_SILENCE, 8'h5A, 4'd10, 80'h9F8000BFA000DFC000FF},
      {1'b1, 1'b1, OP_WRITE,   8'h80, 4'd1,  80'h81},
      {1'b1, 1'b1, OP_WRITE,   8'h00, 4'd2,  80'h8100},
      {1'b1, 1'b1, OP_WRITE,   8'h3F, 4'd2,  80'h803F},
      {1'b1, 1'b1, OP_WRITE,   8'hAF, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'h15, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'hCF, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'h3F, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'hE3, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'hDF, 4'd3,  80'hCE03DF},
      {1'b1, 1'b1, OP_WRITE,   8'h3F, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'hE7, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'h00, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'hC0, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'hE3, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'hBF, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'hF0, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_WRITE,   8'h9F, 4'd0,  80'h0},
      {1'b1, 1'b0, OP_WRITE,   8'hE3, 4'd0,  80'h0},
      {1'b1, 1'b0, OP_WRITE,   8'h3C, 4'd0,  80'h0},
      {1'b1, 1'b1, OP_SILENCE, 8'h00, 4'd10, 80'h9F8000BFA000DFC000FF},
      {1'b1, 1'b1, OP_WRITE,   8'h7F, 4'd0,  80'h0}
   };

   function automatic void add_tone3_period();
      int unsigned p;
      p = 32'(shadow_period[2]);
      if (stretch_en && noise_periodic_q && noise_tone3_q &&
          shadow_atten[2] == psgwsf_pkg::ATT2_MUTED)
         p = p * 10625 / 10000;
      if (p == 0)
         p = 1;
      group_bytes.push_back({psgwsf_pkg::TONE3_LATCH, p[3:0]});
      group_bytes.push_back({2'b00, p[9:4]});
   endfunction

   function automatic void rewrite_command(input logic op, input psgwsf_pkg::byte_type d);
      logic [1:0]             ch;
      psgwsf_pkg::period_type p;
      group_bytes.delete();
      if (op == OP_SILENCE) begin
         shadow_latch = 2'd0;
         for (int t = 0; t < psgwsf_pkg::NUM_TONES; t++)
            shadow_period[t] = '0;
         for (int t = 0; t < 4; t++) begin
            ch = t[1:0];
            group_bytes.push_back({1'b1, ch, 5'h1F});
            if (t != 3) begin
               group_bytes.push_back({1'b1, ch, 5'h00});
               group_bytes.push_back(8'h00);
            end
         end
      end else if (!fix_en) begin
         group_bytes.push_back(d);
      end else if (!d[7]) begin
         ch = (shadow_latch > 2'd2) ? 2'd2 : shadow_latch;
         p = {d[5:0], shadow_period[ch][3:0]};
         shadow_period[ch] = p;
         if (ch == 2'd2) begin
            add_tone3_period();
         end else begin
            group_bytes.push_back({1'b1, ch, 1'b0, p[3:0] | {3'b000, p == '0}});
            group_bytes.push_back({2'b00, p[9:4]});
         end
      end else if (!d[4] && d[6:5] != 2'd3) begin
         ch = d[6:5];
         p = {shadow_period[ch][9:4], d[3:0]};
         shadow_latch = ch;
         shadow_period[ch] = p;
         group_bytes.push_back(d | {7'b0, p == '0});
      end else begin
         if (d[4]) begin
            shadow_atten[d[6:5]] = d;
            if (d[6:5] == 2'd2)
               add_tone3_period();
         end else if (d[7:4] == psgwsf_pkg::NOISE_CTRL) begin
            noise_periodic_q = !d[2];
            noise_tone3_q = (d[1:0] == 2'b11);
            add_tone3_period();
         end
         group_bytes.push_back(d);
      end
   endfunction

   function automatic int sender_gap();
      int r;
      if (steady_send)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // mostly well-formed tone, volume and noise writes, some silence ops and raw random bytes
   function automatic void random_command(output logic op, output psgwsf_pkg::byte_type d);
      int         kind;
      logic [1:0] ch;
      logic [3:0] nib;
      logic [5:0] hi6;
      kind = $urandom_range(0, 99);
      ch   = 2'($urandom_range(0, 2));
      nib  = ($urandom_range(0, 4) == 0) ? 4'h0 : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
         0, 1, 2: hi6 = 6'($urandom_range(60, 63));
         3:       hi6 = 6'h00;
         default: hi6 = 6'($urandom_range(0, 63));
      endcase
      op = OP_WRITE;
      d  = 8'($urandom_range(0, 255));
      if (kind < 5) begin
         op = OP_SILENCE;
      end else if (kind < 33) begin
         d = {1'b1, ch, 1'b0, nib};
      end else if (kind < 58) begin
         d = {2'b00, hi6};
      end else if (kind < 73) begin
         ch = 2'($urandom_range(0, 3));
         d = (ch == 2'd2 && $urandom_range(0, 1)) ? psgwsf_pkg::ATT2_MUTED
                                                  : {1'b1, ch, 1'b1, nib};
      end else if (kind < 85) begin
         d = $urandom_range(0, 2) ? {psgwsf_pkg::NOISE_CTRL, 4'h3}
                                  : {psgwsf_pkg::NOISE_CTRL, nib};
      end
   endfunction

   task automatic push_command(input logic op, input psgwsf_pkg::byte_type d,
                               input int gap, input logic [3:0] n_typed,
                               input logic [79:0] typed);
      bus_byte_type b;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.op        = op;
      req_bus.data_byte = d;
      do @(posedge clock); while (!req_bus.ready);
      rewrite_command(op, d);
      if (n_typed != 0) begin
         group_bytes.delete();
         for (int k = 0; k < n_typed; k++)
            group_bytes.push_back(typed[8*(int'(n_typed)-1-k) +: 8]);
      end
      foreach (group_bytes[k]) begin
         b.out_byte = group_bytes[k];
         b.last     = (k == group_bytes.size() - 1);
         bus_bytes_due.push_back(b);
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (bus_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic val);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = {{(psgwsf_pkg::CSR_DATA_W-1){1'b0}}, val};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == psgwsf_pkg::REG_FIX_ENABLE)
         fix_en = val;
      else
         stretch_en = val;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic apply_settings(input logic fix, input logic stretch);
      wait_for_drain();
      csr_write(psgwsf_pkg::REG_FIX_ENABLE, fix);
      csr_write(psgwsf_pkg::REG_PERIODIC_ENABLE, stretch);
   endtask

   // receiver: runs of ready, stalls mostly short, a few long
   always @(negedge clock) begin
      if (ready_hold == 0) begin
         ready_mode = ($urandom_range(0, 99) < 65);
         if (ready_mode)
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
         else
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
      end
      rsp_bus.ready = ready_mode;
      ready_hold--;
   end

   always @(posedge clock) begin
      bus_byte_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (bus_bytes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer: byte %02h last %0b", $time,
                     rsp_bus.out_byte, rsp_bus.last);
         end else begin
            want = bus_bytes_due.pop_front();
            if (want.out_byte !== rsp_bus.out_byte || want.last !== rsp_bus.last) begin
               errors++;
               $display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                        $time, want.out_byte, want.last, rsp_bus.out_byte, rsp_bus.last);
            end
         end
      end
   end

   initial begin
      stim_row_type         row;
      logic                 op;
      psgwsf_pkg::byte_type d;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_WRITE;
      req_bus.data_byte = '0;
      rsp_bus.ready     = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      apply_settings(1'b0, 1'b0);
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.fix != fix_en || row.stretch != stretch_en)
            apply_settings(row.fix, row.stretch);
         push_command(row.op, row.data, sender_gap(), row.n_typed, row.typed);
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         apply_settings(PHASE_FIX[ph], PHASE_STRETCH[ph]);
         steady_send = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 0 && k == PHASE_ITEMS / 2)
               wait_for_drain();
            random_command(op, d);
            push_command(op, d, sender_gap(), 4'd0, 80'h0);
         end
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (errors == 0 && bus_bytes_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/psgwsf_pkg.sv
hw/rtl/psgwsf_req_if.sv
hw/rtl/psgwsf_rsp_if.sv
hw/rtl/psg_write_stream_fixer.sv
bench/psg_write_stream_fixer_tb.sv
